FILE: design/tsf_pkg.sv
// Shared types and codes for the turn signal and hazard flasher.
// No dependencies; all design files but tsf_if refer to this package by scope.
package tsf_pkg;

  localparam int unsigned CntW = 16;

  // Reset values of the configuration registers
  localparam logic [CntW-1:0] HalfPeriodRst = 16'd345;
  localparam logic [CntW-1:0] BeepLenRst    = 16'd5;

  // Configuration register indexes
  typedef enum logic {
    CfgHalfPeriod = 1'b0,
    CfgBeepLen    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeOff    = 2'd0,
    ModeLeft   = 2'd1,
    ModeRight  = 2'd2,
    ModeHazard = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PhInactive = 3'd0,
    PhStart    = 3'd1,
    PhOnBeep   = 3'd2,
    PhOn       = 3'd3,
    PhOffBeep  = 3'd4,
    PhOff      = 3'd5,
    PhEnd      = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ToneSilent = 2'd0,
    ToneHigh   = 2'd1,
    ToneLow    = 2'd2
  } tone_e;

  // Input levels as sampled per tick
  typedef struct packed {
    logic hazard;
    logic right;
    logic left;
  } levels_t;

  typedef struct packed {
    logic lamp_h;
    logic lamp_r;
    logic lamp_l;
  } lamps_t;

  // Complete flasher state carried between ticks
  typedef struct packed {
    mode_e            mode;
    phase_e           phase;
    logic [CntW-1:0]  step;
    levels_t          prev;
    lamps_t           lamps;
    tone_e            tone;
  } state_t;

  typedef struct packed {
    logic [CntW-1:0] half_period;
    logic [CntW-1:0] beep_len;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic  left_lamp;
    logic  right_lamp;
    logic  hazard_lamp;
    tone_e buzzer_tone;
    mode_e signal_mode;
  } result_t;

endpackage

FILE: design/tsf_if.sv
// Valid/ready channel interfaces for tick requests and lamp/buzzer results.
// Depends on nothing; used by the flasher top level.
interface tsf_in_if;
  logic valid;
  logic ready;
  logic left_switch;
  logic right_switch;
  logic hazard_button;

  modport source (output valid, output left_switch, output right_switch,
                  output hazard_button, input ready);
  modport sink   (input valid, input left_switch, input right_switch,
                  input hazard_button, output ready);
endinterface

interface tsf_out_if;
  logic       valid;
  logic       ready;
  logic       left_lamp;
  logic       right_lamp;
  logic       hazard_lamp;
  logic [1:0] buzzer_tone;
  logic [1:0] signal_mode;

  modport source (output valid, output left_lamp, output right_lamp,
                  output hazard_lamp, output buzzer_tone, output signal_mode,
                  input ready);
  modport sink   (input valid, input left_lamp, input right_lamp,
                  input hazard_lamp, input buzzer_tone, input signal_mode,
                  output ready);
endinterface

FILE: design/tsf_step.sv
// Per-tick next-state logic: switch edge handling, then one flasher step.
// Depends on tsf_pkg.
module tsf_step (
  input  tsf_pkg::state_t  state_i,
  input  tsf_pkg::levels_t levels_i,
  input  tsf_pkg::cfg_t    cfg_i,
  output tsf_pkg::state_t  state_o,
  output tsf_pkg::result_t result_o
);

  typedef struct packed {
    tsf_pkg::mode_e           mode;
    tsf_pkg::phase_e          phase;
    logic [tsf_pkg::CntW-1:0] step;
  } evt_t;

  // Select left/right or stop on turn switch levels; hazard mode masks them
  function automatic evt_t apply_turn(evt_t e, logic l, logic r);
    evt_t o;
    o = e;
    if (e.mode != tsf_pkg::ModeHazard) begin
      case ({l, r})
        2'b00: begin
          o.mode  = tsf_pkg::ModeOff;
          o.phase = tsf_pkg::PhEnd;
          o.step  = '0;
        end
        2'b10: begin
          o.mode  = tsf_pkg::ModeLeft;
          o.phase = tsf_pkg::PhStart;
          o.step  = '0;
        end
        2'b01: begin
          o.mode  = tsf_pkg::ModeRight;
          o.phase = tsf_pkg::PhStart;
          o.step  = '0;
        end
        default: ;
      endcase
    end
    return o;
  endfunction

  tsf_pkg::levels_t         changed;
  evt_t                     ev;
  logic [tsf_pkg::CntW-1:0] passed;
  tsf_pkg::state_t          nxt;

  assign changed = state_i.prev ^ levels_i;

  // Handle hazard press first, then turn switch changes
  always_comb begin
    ev = '{mode: state_i.mode, phase: state_i.phase, step: state_i.step};
    if (changed.hazard && levels_i.hazard) begin
      if (ev.mode == tsf_pkg::ModeHazard) begin
        ev = '{mode: tsf_pkg::ModeOff, phase: tsf_pkg::PhEnd, step: '0};
        ev = apply_turn(ev, levels_i.left, levels_i.right);
      end else begin
        ev = '{mode: tsf_pkg::ModeHazard, phase: tsf_pkg::PhStart, step: '0};
      end
    end
    if (changed.left || changed.right) begin
      ev = apply_turn(ev, levels_i.left, levels_i.right);
    end
  end

  // Saturating tick count for the current phase
  assign passed = (ev.step == '1) ? ev.step : ev.step + tsf_pkg::CntW'(1);

  // Advance the flasher by one tick
  always_comb begin
    nxt       = state_i;
    nxt.prev  = levels_i;
    nxt.mode  = ev.mode;
    nxt.phase = ev.phase;
    nxt.step  = passed;
    unique case (ev.phase)
      tsf_pkg::PhStart, tsf_pkg::PhOff: begin
        if (ev.phase == tsf_pkg::PhStart || passed >= cfg_i.half_period) begin
          nxt.tone = tsf_pkg::ToneHigh;
          case (ev.mode)
            tsf_pkg::ModeLeft:   nxt.lamps = '{lamp_h: 1'b0, lamp_r: 1'b0, lamp_l: 1'b1};
            tsf_pkg::ModeRight:  nxt.lamps = '{lamp_h: 1'b0, lamp_r: 1'b1, lamp_l: 1'b0};
            tsf_pkg::ModeHazard: nxt.lamps = '{lamp_h: 1'b1, lamp_r: 1'b1, lamp_l: 1'b1};
            default: nxt.lamps = '{lamp_h: state_i.lamps.lamp_h, lamp_r: 1'b0,
                                   lamp_l: 1'b0};
          endcase
          nxt.phase = tsf_pkg::PhOnBeep;
          nxt.step  = '0;
        end
      end
      tsf_pkg::PhOnBeep: begin
        if (passed >= cfg_i.beep_len) begin
          nxt.tone  = tsf_pkg::ToneSilent;
          nxt.phase = tsf_pkg::PhOn;
          nxt.step  = '0;
        end
      end
      tsf_pkg::PhOn: begin
        if (passed >= cfg_i.half_period) begin
          nxt.tone  = tsf_pkg::ToneLow;
          nxt.lamps = '0;
          nxt.phase = tsf_pkg::PhOffBeep;
          nxt.step  = '0;
        end
      end
      tsf_pkg::PhOffBeep: begin
        if (passed >= cfg_i.beep_len) begin
          nxt.tone  = tsf_pkg::ToneSilent;
          nxt.phase = tsf_pkg::PhOff;
          nxt.step  = '0;
        end
      end
      tsf_pkg::PhEnd: begin
        nxt.tone  = tsf_pkg::ToneSilent;
        nxt.lamps = '0;
        nxt.phase = tsf_pkg::PhInactive;
        nxt.step  = '0;
      end
      default: begin
        nxt.phase = tsf_pkg::PhInactive;
        nxt.step  = '0;
      end
    endcase
  end

  assign state_o = nxt;

  // Drive the result from the updated state
  always_comb begin
    result_o.left_lamp   = nxt.lamps.lamp_l;
    result_o.right_lamp  = nxt.lamps.lamp_r;
    result_o.hazard_lamp = nxt.lamps.lamp_h;
    result_o.buzzer_tone = nxt.tone;
    result_o.signal_mode = nxt.mode;
  end

endmodule

FILE: design/tsf_res_queue.sv
// Two-entry result buffer that decouples the tick side from the result side.
// Depends on tsf_pkg.
module tsf_res_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tsf_pkg::result_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output tsf_pkg::result_t data_o
);

  tsf_pkg::result_t head_q, head_d, tail_q, tail_d;
  logic [1:0]       cnt_q, cnt_d;

  // Shift and fill the two slots
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      if (cnt_q == 2'd0) begin
        head_d = data_i;
      end else begin
        tail_d = data_i;
      end
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      head_d = tail_q;
      cnt_d  = cnt_q - 2'd1;
    end else if (push_i && pop_i) begin
      if (cnt_q == 2'd1) begin
        head_d = data_i;
      end else begin
        head_d = tail_q;
        tail_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = head_q;

endmodule

FILE: design/turn_signal_hazard_flasher_core.sv
// Top level of the turn signal and hazard flasher: config, state, buffer.
// Depends on tsf_pkg, tsf_if, tsf_step and tsf_res_queue.
//
//   channel | dir | payload                                           | handshake
//   in_i    | in  | left_switch, right_switch, hazard_button         | valid/ready
//   out_o   | out | left_lamp, right_lamp, hazard_lamp, buzzer_tone,  | valid/ready
//           |     | signal_mode                                       |
//   cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i[15:0]             | write enable
//
// One tick request per cycle unless the buffer is full; its result is registered.
// The state update is one pass through the edge and flasher step logic.
// The two-entry result buffer keeps requests flowing while a result waits;
// in_i.ready drops only when both slots hold untaken results.
// Reset clears state and buffer, and loads the register defaults.
module turn_signal_hazard_flasher_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  tsf_in_if.sink           in_i,
  tsf_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [15:0]      cfg_data_i
);

  tsf_pkg::state_t  state_q, state_d, step_state;
  tsf_pkg::cfg_t    cfg_q;
  tsf_pkg::levels_t levels;
  tsf_pkg::result_t step_res, head_res;
  logic             accept, buf_full;

  assign levels = '{hazard: in_i.hazard_button, right: in_i.right_switch,
                    left: in_i.left_switch};
  assign accept = in_i.valid && in_i.ready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= tsf_pkg::HalfPeriodRst;
      cfg_q.beep_len    <= tsf_pkg::BeepLenRst;
    end else if (cfg_we_i) begin
      unique case (tsf_pkg::cfg_idx_e'(cfg_idx_i))
        tsf_pkg::CfgHalfPeriod: cfg_q.half_period <= cfg_data_i;
        tsf_pkg::CfgBeepLen:    cfg_q.beep_len    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tsf_step u_step (
    .state_i  (state_q),
    .levels_i (levels),
    .cfg_i    (cfg_q),
    .state_o  (step_state),
    .result_o (step_res)
  );

  // Advance state only on an accepted request
  assign state_d = accept ? step_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: tsf_pkg::ModeOff, phase: tsf_pkg::PhInactive, step: '0,
                   prev: '0, lamps: '0, tone: tsf_pkg::ToneSilent};
    end else begin
      state_q <= state_d;
    end
  end

  tsf_res_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (step_res),
    .full_o  (buf_full),
    .pop_i   (out_o.valid && out_o.ready),
    .valid_o (out_o.valid),
    .data_o  (head_res)
  );

  assign in_i.ready        = !buf_full;
  assign out_o.left_lamp   = head_res.left_lamp;
  assign out_o.right_lamp  = head_res.right_lamp;
  assign out_o.hazard_lamp = head_res.hazard_lamp;
  assign out_o.buzzer_tone = head_res.buzzer_tone;
  assign out_o.signal_mode = head_res.signal_mode;

endmodule

FILE: design/tsf_checker.sv
// Port-level checks on the flasher top level, attached by bind.
// Depends on turn_signal_hazard_flasher_core and tsf_pkg.
module tsf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       left_lamp,
  input logic       right_lamp,
  input logic       hazard_lamp,
  input logic [1:0] buzzer_tone,
  input logic [1:0] signal_mode
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid &&
      $stable({left_lamp, right_lamp, hazard_lamp, buzzer_tone, signal_mode}))
    else $error("stalled result changed");

  // An empty buffer always takes a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("request refused with empty buffer");

  // Hazard dashboard lamp only lights together with both indicators
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && hazard_lamp |-> left_lamp && right_lamp)
    else $error("hazard lamp lit without both indicators");

  // Indicators are never lit while the mode is off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && signal_mode == tsf_pkg::ModeOff |-> !left_lamp && !right_lamp)
    else $error("indicator lit with mode off");

endmodule

bind turn_signal_hazard_flasher_core tsf_checker u_tsf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .left_lamp   (out_o.left_lamp),
  .right_lamp  (out_o.right_lamp),
  .hazard_lamp (out_o.hazard_lamp),
  .buzzer_tone (out_o.buzzer_tone),
  .signal_mode (out_o.signal_mode)
);

FILE: bench/turn_signal_hazard_flasher_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the turn signal and hazard flasher core.
// Depends on tsf_pkg, tsf_if and turn_signal_hazard_flasher_core.
// A local flasher model predicts each tick's lamp and buzzer result.
module turn_signal_hazard_flasher_core_tb;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxShown   = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  tsf_in_if  tick_if ();
  tsf_out_if lamp_if ();

  turn_signal_hazard_flasher_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_if),
    .out_o      (lamp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Flasher model state and its copy of the registers
  tsf_pkg::mode_e   fl_mode;
  tsf_pkg::phase_e  fl_phase;
  logic [15:0]      fl_step;
  tsf_pkg::levels_t fl_prev;
  tsf_pkg::lamps_t  fl_lamps;
  tsf_pkg::tone_e   fl_tone;
  logic [15:0]      half_len;
  logic [15:0]      beep_len;

  tsf_pkg::levels_t pending_ticks[$];
  tsf_pkg::result_t expected_lamps[$];
  int               outstanding;
  int               err_cnt;
  int               in_gap;
  int               in_burst;
  int               out_hold;
  int               out_burst;
  int unsigned      idle_cycles;
  tsf_pkg::levels_t tick_lv;
  tsf_pkg::result_t exp_r;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Pick an idle length: mostly none or short, a few long, with bursts of none
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) begin
      burst = $urandom_range(20, 200);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply turn switch levels unless hazard mode holds the flasher
  function automatic void select_turn(tsf_pkg::levels_t lv);
    if (fl_mode == tsf_pkg::ModeHazard) return;
    if (!lv.left && !lv.right) begin
      fl_phase = tsf_pkg::PhEnd;
      fl_step  = '0;
      fl_mode  = tsf_pkg::ModeOff;
    end else if (lv.left && !lv.right) begin
      fl_mode  = tsf_pkg::ModeLeft;
      fl_phase = tsf_pkg::PhStart;
      fl_step  = '0;
    end else if (!lv.left && lv.right) begin
      fl_mode  = tsf_pkg::ModeRight;
      fl_phase = tsf_pkg::PhStart;
      fl_step  = '0;
    end
  endfunction

  // Handle level changes, then advance the flasher by one tick
  function automatic tsf_pkg::result_t flasher_tick(tsf_pkg::levels_t lv);
    tsf_pkg::levels_t chg;
    logic [15:0]      passed;
    logic [15:0]      nxt;
    tsf_pkg::result_t res;
    chg     = lv ^ fl_prev;
    fl_prev = lv;

    if (chg.hazard && lv.hazard) begin
      if (fl_mode == tsf_pkg::ModeHazard) begin
        fl_phase = tsf_pkg::PhEnd;
        fl_step  = '0;
        fl_mode  = tsf_pkg::ModeOff;
        select_turn(lv);
      end else begin
        fl_mode  = tsf_pkg::ModeHazard;
        fl_phase = tsf_pkg::PhStart;
        fl_step  = '0;
      end
    end
    if (chg.left || chg.right) select_turn(lv);

    passed = (fl_step == 16'hFFFF) ? fl_step : fl_step + 16'd1;
    nxt    = passed;
    case (fl_phase)
      tsf_pkg::PhStart, tsf_pkg::PhOff: begin
        if (fl_phase == tsf_pkg::PhStart || passed >= half_len) begin
          fl_tone = tsf_pkg::ToneHigh;
          case (fl_mode)
            tsf_pkg::ModeLeft: begin
              fl_lamps        = '0;
              fl_lamps.lamp_l = 1'b1;
            end
            tsf_pkg::ModeRight: begin
              fl_lamps        = '0;
              fl_lamps.lamp_r = 1'b1;
            end
            tsf_pkg::ModeHazard: fl_lamps = '1;
            default: begin
              fl_lamps.lamp_l = 1'b0;
              fl_lamps.lamp_r = 1'b0;
            end
          endcase
          fl_phase = tsf_pkg::PhOnBeep;
          nxt      = '0;
        end
      end
      tsf_pkg::PhOnBeep: begin
        if (passed >= beep_len) begin
          fl_tone  = tsf_pkg::ToneSilent;
          fl_phase = tsf_pkg::PhOn;
          nxt      = '0;
        end
      end
      tsf_pkg::PhOn: begin
        if (passed >= half_len) begin
          fl_tone  = tsf_pkg::ToneLow;
          fl_lamps = '0;
          fl_phase = tsf_pkg::PhOffBeep;
          nxt      = '0;
        end
      end
      tsf_pkg::PhOffBeep: begin
        if (passed >= beep_len) begin
          fl_tone  = tsf_pkg::ToneSilent;
          fl_phase = tsf_pkg::PhOff;
          nxt      = '0;
        end
      end
      tsf_pkg::PhEnd: begin
        fl_tone  = tsf_pkg::ToneSilent;
        fl_lamps = '0;
        fl_phase = tsf_pkg::PhInactive;
        nxt      = '0;
      end
      default: begin
        fl_phase = tsf_pkg::PhInactive;
        nxt      = '0;
      end
    endcase
    fl_step = nxt;

    res.left_lamp   = fl_lamps.lamp_l;
    res.right_lamp  = fl_lamps.lamp_r;
    res.hazard_lamp = fl_lamps.lamp_h;
    res.buzzer_tone = fl_tone;
    res.signal_mode = fl_mode;
    return res;
  endfunction

  // Driver: offer queued ticks, predict each accepted one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        tick_lv.left   = tick_if.left_switch;
        tick_lv.right  = tick_if.right_switch;
        tick_lv.hazard = tick_if.hazard_button;
        expected_lamps.push_back(flasher_tick(tick_lv));
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (in_gap > 0) begin
          tick_if.valid <= 1'b0;
          in_gap--;
        end else if (pending_ticks.size() > 0) begin
          tick_lv = pending_ticks.pop_front();
          tick_if.left_switch   <= tick_lv.left;
          tick_if.right_switch  <= tick_lv.right;
          tick_if.hazard_button <= tick_lv.hazard;
          tick_if.valid         <= 1'b1;
          in_gap = pick_gap(in_burst);
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each result with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      lamp_if.ready <= 1'b0;
    end else begin
      if (lamp_if.valid && lamp_if.ready) begin
        if (expected_lamps.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxShown)
            $display("%0t: result with no tick pending: L%0b R%0b H%0b tone %0d mode %0d",
                     $realtime, lamp_if.left_lamp, lamp_if.right_lamp,
                     lamp_if.hazard_lamp, lamp_if.buzzer_tone, lamp_if.signal_mode);
        end else begin
          exp_r = expected_lamps.pop_front();
          outstanding--;
          if (lamp_if.left_lamp !== exp_r.left_lamp ||
              lamp_if.right_lamp !== exp_r.right_lamp ||
              lamp_if.hazard_lamp !== exp_r.hazard_lamp ||
              lamp_if.buzzer_tone !== exp_r.buzzer_tone ||
              lamp_if.signal_mode !== exp_r.signal_mode) begin
            err_cnt++;
            if (err_cnt <= MaxShown)
              $display("%0t: expected LRH %0b%0b%0b tone %0d mode %0d, got %0b%0b%0b %0d %0d",
                       $realtime, exp_r.left_lamp, exp_r.right_lamp, exp_r.hazard_lamp,
                       exp_r.buzzer_tone, exp_r.signal_mode, lamp_if.left_lamp,
                       lamp_if.right_lamp, lamp_if.hazard_lamp, lamp_if.buzzer_tone,
                       lamp_if.signal_mode);
          end
        end
      end
      if (out_hold > 0) begin
        lamp_if.ready <= 1'b0;
        out_hold--;
      end else begin
        lamp_if.ready <= 1'b1;
        out_hold = pick_gap(out_burst);
      end
    end
  end

  // Watchdog: end the run when neither side moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tick_if.valid && tick_if.ready) || (lamp_if.valid && lamp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: watchdog expired with %0d ticks outstanding",
                 $realtime, outstanding);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_hold(tsf_pkg::levels_t lv, int n);
    repeat (n) pending_ticks.push_back(lv);
    outstanding += n;
  endtask

  // Hold until every queued tick has its result back, then settle
  task automatic wait_idle();
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [15:0] half, logic [15:0] beep);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= tsf_pkg::CfgHalfPeriod;
    cfg_data_i <= half;
    @(posedge clk_i);
    cfg_idx_i  <= tsf_pkg::CfgBeepLen;
    cfg_data_i <= beep;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    half_len = half;
    beep_len = beep;
  endtask

  // Mostly held switch patterns and hazard presses, some level noise
  task automatic gen_traffic(int n, int span);
    tsf_pkg::levels_t lv;
    int               cnt;
    int               run;
    int               kind;
    lv  = '0;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        lv.left   = 1'($urandom_range(0, 1));
        lv.right  = 1'($urandom_range(0, 1));
        lv.hazard = 1'b0;
        run = $urandom_range(1, span);
        push_hold(lv, run);
        cnt += run;
      end else if (kind < 85) begin
        lv.hazard = 1'b1;
        run = $urandom_range(1, 4);
        push_hold(lv, run);
        cnt += run;
        lv.hazard = 1'b0;
        run = $urandom_range(1, span);
        push_hold(lv, run);
        cnt += run;
      end else begin
        run = $urandom_range(1, 6);
        repeat (run) begin
          lv = tsf_pkg::levels_t'(3'($urandom_range(0, 7)));
          push_hold(lv, 1);
        end
        cnt += run;
      end
    end
  endtask

  initial begin
    int unsigned h;
    int unsigned b;

    tick_if.valid         = 1'b0;
    tick_if.left_switch   = 1'b0;
    tick_if.right_switch  = 1'b0;
    tick_if.hazard_button = 1'b0;
    lamp_if.ready         = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = tsf_pkg::CfgHalfPeriod;
    cfg_data_i            = '0;
    rst_ni                = 1'b0;

    fl_mode     = tsf_pkg::ModeOff;
    fl_phase    = tsf_pkg::PhInactive;
    fl_step     = '0;
    fl_prev     = '0;
    fl_lamps    = '0;
    fl_tone     = tsf_pkg::ToneSilent;
    half_len    = tsf_pkg::HalfPeriodRst;
    beep_len    = tsf_pkg::BeepLenRst;
    outstanding = 0;
    err_cnt     = 0;
    in_gap      = 0;
    in_burst    = 0;
    out_hold    = 0;
    out_burst   = 0;
    idle_cycles = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks at reset register values; levels are {hazard, right, left}
    push_hold(3'b000, 1);  // no change
    push_hold(3'b001, 2);  // left selected
    push_hold(3'b011, 1);  // both on: ignored
    push_hold(3'b010, 1);  // right restarts the flash
    push_hold(3'b000, 2);  // both off: stop
    push_hold(3'b100, 2);  // hazard press
    push_hold(3'b000, 1);  // hazard release: no effect
    push_hold(3'b001, 1);  // turn change ignored in hazard mode
    push_hold(3'b101, 2);  // hazard off, fall back to left
    push_hold(3'b111, 1);  // both on: left keeps running
    push_hold(3'b011, 1);  // hazard falling edge
    push_hold(3'b110, 2);  // hazard press with turn change in the same tick
    push_hold(3'b111, 2);  // left on: ignored, hazard mode still holds
    push_hold(3'b001, 1);  // ignored in hazard mode
    push_hold(3'b010, 1);  // ignored in hazard mode
    push_hold(3'b100, 1);  // hazard off, both switches off: stop
    push_hold(3'b011, 1);  // both on: ignored
    push_hold(3'b111, 1);  // hazard on
    push_hold(3'b000, 1);
    // Run one full flash period at the reset timing
    push_hold(3'b001, 705);
    push_hold(3'b100, 3);
    push_hold(3'b000, 20);
    wait_idle();

    // Zero registers act as one tick
    load_regs(16'd0, 16'd0);
    gen_traffic(80, 10);
    wait_idle();

    load_regs(16'd1, 16'd1);
    gen_traffic(80, 12);
    wait_idle();

    load_regs(16'd3, 16'd2);
    gen_traffic(80, 20);
    wait_idle();

    h = $urandom_range(1, 12);
    b = $urandom_range(1, 8);
    load_regs(h[15:0], b[15:0]);
    gen_traffic(80, int'(2 * (h + b) + 8));
    wait_idle();

    load_regs(16'd2, 16'd1);
    gen_traffic(60, 14);
    wait_idle();

    repeat (16) @(posedge clk_i);
    if (expected_lamps.size() != 0) err_cnt++;
    if (err_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
